// File: rtl/fmve_pkg.sv
// ----------------------------------------------------------------------------
// fmve_pkg: shared types and constants
// Register indexes, field widths and the datapath command word.
// ----------------------------------------------------------------------------
package fmve_pkg;

	localparam int ENERGY_BITS_DEF = 48;
	localparam int TAP_BITS_DEF    = 16;
	localparam int STAMP_W         = 32;
	localparam int VOLT_W          = 24;
	localparam int TAPF_W          = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int SQRT_STEPS      = 32;
	localparam int DIV_STEPS       = 24;
	localparam int STEP_CNT_W      = 6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_DRAIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_SCALE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_TAP_GAIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TAP_GAIN = 3'd5;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_EDGE,
		OP_TICK,
		OP_MUL_PP,
		OP_MUL_ALO,
		OP_MUL_AHI,
		OP_MUL_DRAIN,
		OP_ENERGY,
		OP_MUL_SLO,
		OP_MUL_SHI,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_MUL_T1,
		OP_MUL_T2
	} fmve_op_t;

	typedef struct packed {
		fmve_op_t op;
		logic     out_load;
	} fmve_cmd_t;

endpackage

// File: rtl/fmve_if.sv
// ----------------------------------------------------------------------------
// fmve_if: channel interfaces
// Input event channel and result channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fmve_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        drive_level;
	logic [31:0] cycle_now;

	modport source(output valid, func, drive_level, cycle_now, input ready);
	modport sink(input valid, func, drive_level, cycle_now, output ready);
endinterface

interface fmve_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] output_volts;
	logic [23:0] first_stage_volts;
	logic [15:0] first_tap_value;
	logic [15:0] output_tap_value;

	modport source(output valid, output_volts, first_stage_volts, first_tap_value,
		output_tap_value, input ready);
	modport sink(input valid, output_volts, first_stage_volts, first_tap_value,
		output_tap_value, output ready);
endinterface

// File: rtl/flyback_multiplier_voltage_emulator_top.sv
// ----------------------------------------------------------------------------
// flyback_multiplier_voltage_emulator_top: flyback multiplier emulator
// Integrates drive pulses into stored energy and reports voltages and taps.
// ----------------------------------------------------------------------------
// A drive-edge word (func 0) is accepted and yields no result. An
// update tick (func 1) runs from acceptance to a result word through the
// products on one shared 32x32 multiplier and the energy update, the
// two-bits-per-step square root, the restoring divide by the stage count,
// the tap products and the load of the output register.
// The input is held off while a tick is in progress; a finished result waits
// in the output register while the next word is accepted.
module flyback_multiplier_voltage_emulator_top #(
	parameter int ENERGY_BITS = fmve_pkg::ENERGY_BITS_DEF,
	parameter int TAP_BITS    = fmve_pkg::TAP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fmve_in_if.sink                         in_ch,
	fmve_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [fmve_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fmve_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fmve_pkg::*;

	fmve_cmd_t cmd;

	// Sequencer.
	fmve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_func   (in_ch.func),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// Datapath.
	fmve_dp #(
		.ENERGY_BITS (ENERGY_BITS),
		.TAP_BITS    (TAP_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.drive_level       (in_ch.drive_level),
		.cycle_now         (in_ch.cycle_now),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.output_volts      (out_ch.output_volts),
		.first_stage_volts (out_ch.first_stage_volts),
		.first_tap_value   (out_ch.first_tap_value),
		.output_tap_value  (out_ch.output_tap_value)
	);

	// The per-stage voltage never exceeds the output voltage.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.first_stage_volts <= out_ch.output_volts)
		else $error("first stage volts above output volts");

	// An edge word never produces a result in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !in_ch.func && !out_ch.valid) |=> !out_ch.valid)
		else $error("result produced by a drive edge");

	// A new result only appears while the input was held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> !$past(in_ch.ready))
		else $error("result appeared without a tick in progress");

endmodule

// File: rtl/fmve_dp.sv
// ----------------------------------------------------------------------------
// fmve_dp: emulator datapath
// Holds configuration and emulator state, one shared 32x32 multiplier,
// the bit-pair square root and the restoring stage divider.
// ----------------------------------------------------------------------------
module fmve_dp #(
	parameter int ENERGY_BITS = fmve_pkg::ENERGY_BITS_DEF,
	parameter int TAP_BITS    = fmve_pkg::TAP_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fmve_pkg::fmve_cmd_t                 cmd,
	input  logic                                drive_level,
	input  logic [fmve_pkg::STAMP_W-1:0]        cycle_now,
	input  logic                                cfg_we,
	input  logic [fmve_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fmve_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [fmve_pkg::VOLT_W-1:0]         output_volts,
	output logic [fmve_pkg::VOLT_W-1:0]         first_stage_volts,
	output logic [fmve_pkg::TAPF_W-1:0]         first_tap_value,
	output logic [fmve_pkg::TAPF_W-1:0]         output_tap_value
);
	import fmve_pkg::*;

	localparam logic [65:0] EMAX = (66'd1 << ENERGY_BITS) - 66'd1;
	localparam logic [39:0] TMAX = (40'd1 << TAP_BITS) - 40'd1;

	// Configuration registers.
	logic [31:0] in_gain_q, out_drain_q, energy_scale_q;
	logic [6:0]  stage_count_q;
	logic [15:0] first_tap_gain_q, output_tap_gain_q;

	// Emulator state.
	logic [ENERGY_BITS-1:0] energy_q;
	logic                   switch_on_q;
	logic [31:0]            start_q, pending_q, last_q;

	// Working registers.
	logic [31:0] p_q, dt_q;
	logic [63:0] mul_q, pp_q, lo_q, rad_q, res_q, bit_q;
	logic [47:0] add_q;
	logic [23:0] volts_q, quo_q, tap1_q;
	logic [6:0]  rem_q, div_q;

	// Multiplier operand selection.
	logic [31:0] ma, mb;
	logic [63:0] e64;
	always_comb begin
		e64 = 64'(energy_q);
		ma  = '0;
		mb  = '0;
		unique case (cmd.op)
			OP_MUL_PP: begin
				ma = p_q;
				mb = p_q;
			end
			OP_MUL_ALO: begin
				ma = mul_q[31:0];
				mb = in_gain_q;
			end
			OP_MUL_AHI: begin
				ma = pp_q[63:32];
				mb = in_gain_q;
			end
			OP_MUL_DRAIN: begin
				ma = out_drain_q;
				mb = dt_q;
			end
			OP_MUL_SLO: begin
				ma = e64[31:0];
				mb = energy_scale_q;
			end
			OP_MUL_SHI: begin
				ma = e64[63:32];
				mb = energy_scale_q;
			end
			OP_MUL_T1: begin
				ma = 32'(quo_q);
				mb = 32'(first_tap_gain_q);
			end
			OP_MUL_T2: begin
				ma = 32'(volts_q);
				mb = 32'(output_tap_gain_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Combined wide products and helper values.
	logic [95:0] prod96;
	logic [65:0] ne_raw;
	logic [63:0] sq_t;
	logic [7:0]  div_trial;
	logic [39:0] tap_raw;
	logic [31:0] edge_d, edge_s;
	logic [23:0] tap_sat;
	always_comb begin
		prod96    = {mul_q, 32'd0} + {32'd0, lo_q};
		ne_raw    = {2'b00, e64} + {18'd0, add_q} - {18'd0, mul_q[63:16]};
		sq_t      = res_q + bit_q;
		div_trial = {rem_q, quo_q[23]} - {1'b0, div_q};
		tap_raw   = mul_q[39:0] >> 16;
		tap_sat   = (tap_raw > TMAX) ? TMAX[23:0] : tap_raw[23:0];
		edge_d    = cycle_now - start_q;
		edge_s    = pending_q + edge_d;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_gain_q         <= '0;
			out_drain_q       <= '0;
			energy_scale_q    <= '0;
			stage_count_q     <= 7'd1;
			first_tap_gain_q  <= '0;
			output_tap_gain_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IN_GAIN:         in_gain_q         <= cfg_data;
				REG_OUT_DRAIN:       out_drain_q       <= cfg_data;
				REG_ENERGY_SCALE:    energy_scale_q    <= cfg_data;
				REG_STAGE_COUNT:     stage_count_q     <= cfg_data[6:0];
				REG_FIRST_TAP_GAIN:  first_tap_gain_q  <= cfg_data[15:0];
				REG_OUTPUT_TAP_GAIN: output_tap_gain_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Emulator state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q    <= '0;
			switch_on_q <= 1'b0;
			start_q     <= '0;
			pending_q   <= '0;
			last_q      <= '0;
		end else begin
			if (cmd.op == OP_EDGE) begin
				if (!drive_level) begin
					if (!switch_on_q) begin
						switch_on_q <= 1'b1;
						start_q     <= cycle_now;
					end
				end else if (switch_on_q) begin
					switch_on_q <= 1'b0;
					if (start_q != '0) begin
						pending_q <= (edge_s < edge_d) ? 32'hFFFF_FFFF : edge_s;
					end
				end
			end
			if (cmd.op == OP_TICK) begin
				pending_q <= '0;
				last_q    <= cycle_now;
			end
			if (cmd.op == OP_ENERGY) begin
				if (ne_raw[65]) begin
					energy_q <= '0;
				end else if (ne_raw > EMAX) begin
					energy_q <= EMAX[ENERGY_BITS-1:0];
				end else begin
					energy_q <= ne_raw[ENERGY_BITS-1:0];
				end
			end
		end
	end

	// Working registers for one tick.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_TICK: begin
				p_q  <= pending_q;
				dt_q <= cycle_now - last_q;
			end
			OP_MUL_PP:    mul_q <= ma * mb;
			OP_MUL_ALO: begin
				pp_q  <= mul_q;
				mul_q <= ma * mb;
			end
			OP_MUL_AHI: begin
				lo_q  <= mul_q;
				mul_q <= ma * mb;
			end
			OP_MUL_DRAIN: begin
				add_q <= prod96[95:48];
				mul_q <= ma * mb;
			end
			OP_MUL_SLO:   mul_q <= ma * mb;
			OP_MUL_SHI: begin
				lo_q  <= mul_q;
				mul_q <= ma * mb;
			end
			OP_SQRT_INIT: begin
				rad_q <= prod96[95:32];
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			OP_SQRT_STEP: begin
				if (rad_q >= sq_t) begin
					rad_q <= rad_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT: begin
				volts_q <= (res_q > 64'hFF_FFFF) ? 24'hFF_FFFF : res_q[23:0];
				quo_q   <= (res_q > 64'hFF_FFFF) ? 24'hFF_FFFF : res_q[23:0];
				rem_q   <= '0;
				div_q   <= (stage_count_q == '0) ? 7'd1 : stage_count_q;
			end
			OP_DIV_STEP: begin
				if (!div_trial[7]) begin
					rem_q <= div_trial[6:0];
					quo_q <= {quo_q[22:0], 1'b1};
				end else begin
					rem_q <= {rem_q[5:0], quo_q[23]};
					quo_q <= {quo_q[22:0], 1'b0};
				end
			end
			OP_MUL_T1:    mul_q <= ma * mb;
			OP_MUL_T2: begin
				tap1_q <= tap_sat;
				mul_q  <= ma * mb;
			end
			default: ;
		endcase
	end

	// Result register, loaded when the word is handed to the output.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			output_volts      <= volts_q;
			first_stage_volts <= quo_q;
			first_tap_value   <= tap1_q[15:0];
			output_tap_value  <= tap_sat[15:0];
		end
	end

endmodule

// File: rtl/fmve_ctrl.sv
// ----------------------------------------------------------------------------
// fmve_ctrl: emulator sequencer
// Accepts events, steps the datapath through a tick and owns output valid.
// ----------------------------------------------------------------------------
module fmve_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_func,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output fmve_pkg::fmve_cmd_t cmd
);
	import fmve_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PP, ST_ALO, ST_AHI, ST_DRAIN, ST_ENERGY, ST_SLO, ST_SHI,
		ST_SQI, ST_SQS, ST_DVI, ST_DVS, ST_T1, ST_T2, ST_DONE
	} state_t;

	state_t                state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  out_valid_q;
	logic                  accept, load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Command decode from state.
	always_comb begin
		cmd.out_load = load;
		unique case (state_q)
			ST_IDLE:   cmd.op = !accept ? OP_NONE : (in_func ? OP_TICK : OP_EDGE);
			ST_PP:     cmd.op = OP_MUL_PP;
			ST_ALO:    cmd.op = OP_MUL_ALO;
			ST_AHI:    cmd.op = OP_MUL_AHI;
			ST_DRAIN:  cmd.op = OP_MUL_DRAIN;
			ST_ENERGY: cmd.op = OP_ENERGY;
			ST_SLO:    cmd.op = OP_MUL_SLO;
			ST_SHI:    cmd.op = OP_MUL_SHI;
			ST_SQI:    cmd.op = OP_SQRT_INIT;
			ST_SQS:    cmd.op = OP_SQRT_STEP;
			ST_DVI:    cmd.op = OP_DIV_INIT;
			ST_DVS:    cmd.op = OP_DIV_STEP;
			ST_T1:     cmd.op = OP_MUL_T1;
			ST_T2:     cmd.op = OP_MUL_T2;
			default:   cmd.op = OP_NONE;
		endcase
	end

	// Sequencer state, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (accept && in_func) state_q <= ST_PP;
				ST_PP:     state_q <= ST_ALO;
				ST_ALO:    state_q <= ST_AHI;
				ST_AHI:    state_q <= ST_DRAIN;
				ST_DRAIN:  state_q <= ST_ENERGY;
				ST_ENERGY: state_q <= ST_SLO;
				ST_SLO:    state_q <= ST_SHI;
				ST_SHI:    state_q <= ST_SQI;
				ST_SQI: begin
					cnt_q   <= '0;
					state_q <= ST_SQS;
				end
				ST_SQS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_CNT_W'(SQRT_STEPS - 1)) state_q <= ST_DVI;
				end
				ST_DVI: begin
					cnt_q   <= '0;
					state_q <= ST_DVS;
				end
				ST_DVS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_CNT_W'(DIV_STEPS - 1)) state_q <= ST_T1;
				end
				ST_T1:     state_q <= ST_T2;
				ST_T2:     state_q <= ST_DONE;
				ST_DONE: begin
					if (load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
